[rtl/jbt_pkg.sv]
// Shared types and codes for the journal block tracker.
`default_nettype none

package jbt_pkg;

	// Request command codes.
	typedef enum logic [1:0] {
		CMD_BEGIN       = 2'd0,
		CMD_WRITE       = 2'd1,
		CMD_END         = 2'd2,
		CMD_COMMIT_DONE = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [3:0] {
		ST_BEGUN        = 4'd0,
		ST_WAIT_BUSY    = 4'd1,
		ST_WAIT_ROOM    = 4'd2,
		ST_NEW_SLOT     = 4'd3,
		ST_ABSORBED     = 4'd4,
		ST_FULL         = 4'd5,
		ST_NO_OP        = 4'd6,
		ST_ENDED        = 4'd7,
		ST_COMMIT_ENTRY = 4'd8,
		ST_CLEARED      = 4'd9
	} status_t;

	// Source of the slot number reported with a single result.
	typedef enum logic [1:0] {
		SLOT_ZERO  = 2'd0,
		SLOT_SCAN  = 2'd1,
		SLOT_COUNT = 2'd2
	} slot_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      idle;
		logic      res_load;
		status_t   res_status;
		slot_sel_t res_slot;
		logic      op_begin;
		logic      op_end;
		logic      set_busy;
		logic      clear_table;
		logic      scan_start;
		logic      scan_step;
		logic      append;
		logic      emit_start;
		logic      emit_step;
		logic      out_load;
	} jbt_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic req_valid;
		logic busy;
		logic room_ok;
		logic open_zero;
		logic open_last;
		logic full;
		logic count_zero;
		logic hit;
		logic scan_end;
		logic emit_last;
		logic can_load;
	} jbt_stat_t;

endpackage

`default_nettype wire

[rtl/jbt_req_if.sv]
// Request channel of the journal block tracker.
`default_nettype none

interface jbt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] block_number;

	modport source(output valid, output command, output block_number, input ready);
	modport sink(input valid, input command, input block_number, output ready);
endinterface

`default_nettype wire

[rtl/jbt_rsp_if.sv]
// Result channel of the journal block tracker.
`default_nettype none

interface jbt_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [5:0]  slot_index;
	logic [31:0] logged_block;
	logic        last;

	modport source(output valid, output status, output slot_index, output logged_block,
		output last, input ready);
	modport sink(input valid, input status, input slot_index, input logged_block,
		input last, output ready);
endinterface

`default_nettype wire

[rtl/jbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds when not reading.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/jbt_ctrl.sv]
// Controller state machine of the journal block tracker.
`default_nettype none

module jbt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jbt_pkg::jbt_stat_t stat,
	output      jbt_pkg::jbt_ctl_t  ctl
);
	import jbt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FINISH,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands.
	always_comb begin
		ctl = '0;
		ctl.res_status = ST_BEGUN;
		ctl.res_slot = SLOT_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (stat.req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FINISH;
				unique case (stat.cmd)
					CMD_BEGIN: begin
						ctl.res_load = 1'b1;
						priority if (stat.busy) begin
							ctl.res_status = ST_WAIT_BUSY;
						end else if (!stat.room_ok) begin
							ctl.res_status = ST_WAIT_ROOM;
						end else begin
							ctl.res_status = ST_BEGUN;
							ctl.op_begin = 1'b1;
						end
					end
					CMD_WRITE: begin
						priority if (stat.full) begin
							ctl.res_load = 1'b1;
							ctl.res_status = ST_FULL;
						end else if (stat.open_zero) begin
							ctl.res_load = 1'b1;
							ctl.res_status = ST_NO_OP;
						end else begin
							ctl.scan_start = 1'b1;
							state_d = S_SCAN;
						end
					end
					CMD_END: begin
						priority if (stat.open_zero) begin
							ctl.res_load = 1'b1;
							ctl.res_status = ST_NO_OP;
						end else if (stat.open_last && !stat.count_zero) begin
							ctl.op_end = 1'b1;
							ctl.set_busy = 1'b1;
							ctl.emit_start = 1'b1;
							state_d = S_EMIT;
						end else begin
							ctl.op_end = 1'b1;
							ctl.set_busy = stat.open_last;
							ctl.res_load = 1'b1;
							ctl.res_status = ST_ENDED;
						end
					end
					CMD_COMMIT_DONE: begin
						ctl.clear_table = 1'b1;
						ctl.res_load = 1'b1;
						ctl.res_status = ST_CLEARED;
					end
				endcase
			end
			S_SCAN: begin
				priority if (stat.hit) begin
					ctl.res_load = 1'b1;
					ctl.res_status = ST_ABSORBED;
					ctl.res_slot = SLOT_SCAN;
					state_d = S_FINISH;
				end else if (stat.scan_end) begin
					ctl.res_load = 1'b1;
					ctl.res_status = ST_NEW_SLOT;
					ctl.res_slot = SLOT_COUNT;
					ctl.append = 1'b1;
					state_d = S_FINISH;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (stat.can_load) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (stat.can_load) begin
					ctl.emit_step = 1'b1;
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/jbt_datapath.sv]
// Datapath of the journal block tracker: counters, slot table and result register.
`default_nettype none

module jbt_datapath #(
	parameter int LOG_SLOTS  = 32,
	parameter int OP_RESERVE = 8,
	parameter int BLOCK_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	jbt_req_if.sink                 req,
	jbt_rsp_if.source               rsp,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_wdata,
	input  wire jbt_pkg::jbt_ctl_t  ctl,
	output      jbt_pkg::jbt_stat_t stat
);
	import jbt_pkg::*;

	localparam int IDX_W   = $clog2(LOG_SLOTS);
	localparam int CNT_W   = $clog2(LOG_SLOTS + 1);
	localparam int STORE_W = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;
	localparam int ROOM_W  = $clog2(64 * OP_RESERVE + LOG_SLOTS + 1);

	// Latched request.
	logic [1:0]         cmd_q;
	logic [STORE_W-1:0] blk_q;

	// Journal state.
	logic [6:0]       lab_q;
	logic [CNT_W-1:0] entry_cnt_q;
	logic [5:0]       open_q;
	logic             busy_q;

	// Walk over the slot table.
	logic [CNT_W-1:0] idx_q;
	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;

	// Pending single result.
	status_t          res_status_q;
	logic [IDX_W-1:0] res_slot_q;
	logic             res_show_q;

	// Result register.
	logic        rsp_valid_q;
	logic [3:0]  rsp_status_q;
	logic [5:0]  rsp_slot_q;
	logic [31:0] rsp_blk_q;
	logic        rsp_last_q;

	// Slot table port signals.
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [STORE_W-1:0] ram_rdata;

	logic              scan_more;
	logic              emit_last;
	logic              can_load;
	logic [ROOM_W-1:0] room_need;
	logic [IDX_W-1:0]  emit_slot;

	assign scan_more = idx_q < entry_cnt_q;
	assign emit_last = idx_q == entry_cnt_q;
	assign can_load  = !rsp_valid_q || rsp.ready;
	assign emit_slot = IDX_W'(idx_q - CNT_W'(1));
	assign room_need = ROOM_W'(entry_cnt_q)
		+ ROOM_W'({1'b0, open_q} + 7'd1) * ROOM_W'(OP_RESERVE);

	// Status toward the controller.
	always_comb begin
		stat.cmd        = cmd_t'(cmd_q);
		stat.req_valid  = req.valid;
		stat.busy       = busy_q;
		stat.room_ok    = (open_q != 6'd63) && (room_need <= ROOM_W'(LOG_SLOTS));
		stat.open_zero  = open_q == 6'd0;
		stat.open_last  = open_q == 6'd1;
		stat.full       = (entry_cnt_q == CNT_W'(LOG_SLOTS))
			|| (8'(entry_cnt_q) + 8'd1 >= {1'b0, lab_q});
		stat.count_zero = entry_cnt_q == '0;
		stat.hit        = pend_s1 && (ram_rdata == blk_q);
		stat.scan_end   = !pend_s1 && !scan_more;
		stat.emit_last  = emit_last;
		stat.can_load   = can_load;
	end

	assign req.ready = ctl.idle;

	// Read address selection for the slot table.
	always_comb begin
		ram_re = 1'b0;
		ram_raddr = idx_q[IDX_W-1:0];
		priority if (ctl.emit_start) begin
			ram_re = 1'b1;
			ram_raddr = '0;
		end else if (ctl.scan_step) begin
			ram_re = scan_more;
		end else if (ctl.emit_step) begin
			ram_re = !emit_last;
		end else begin
			ram_re = 1'b0;
		end
	end

	jbt_ram #(
		.WIDTH(STORE_W),
		.DEPTH(LOG_SLOTS)
	) u_slot_table (
		.clk  (clk),
		.we   (ctl.append),
		.waddr(entry_cnt_q[IDX_W-1:0]),
		.wdata(blk_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control registers: counters, walk pointer and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lab_q       <= 7'd33;
			entry_cnt_q <= '0;
			open_q      <= '0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lab_q <= cfg_wdata;
			end
			if (ctl.clear_table) begin
				entry_cnt_q <= '0;
			end else if (ctl.append) begin
				entry_cnt_q <= entry_cnt_q + CNT_W'(1);
			end
			if (ctl.op_begin) begin
				open_q <= open_q + 6'd1;
			end else if (ctl.op_end) begin
				open_q <= open_q - 6'd1;
			end
			if (ctl.clear_table) begin
				busy_q <= 1'b0;
			end else if (ctl.set_busy) begin
				busy_q <= 1'b1;
			end
			priority if (ctl.scan_start) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (ctl.emit_start) begin
				idx_q <= CNT_W'(1);
			end else if (ctl.scan_step) begin
				pend_s1 <= scan_more;
				if (scan_more) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end else if (ctl.emit_step && !emit_last) begin
				idx_q <= idx_q + CNT_W'(1);
			end else begin
				idx_q <= idx_q;
			end
			if (ctl.out_load || ctl.emit_step) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctl.idle && req.valid) begin
			cmd_q <= req.command;
			blk_q <= req.block_number[STORE_W-1:0];
		end
		if (ctl.scan_step) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			unique case (ctl.res_slot)
				SLOT_SCAN: begin
					res_slot_q <= idx_s1;
					res_show_q <= 1'b1;
				end
				SLOT_COUNT: begin
					res_slot_q <= entry_cnt_q[IDX_W-1:0];
					res_show_q <= 1'b1;
				end
				default: begin
					res_slot_q <= '0;
					res_show_q <= 1'b0;
				end
			endcase
		end
		if (ctl.out_load) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= 6'(res_slot_q);
			rsp_blk_q    <= res_show_q ? 32'(blk_q) : 32'd0;
			rsp_last_q   <= 1'b1;
		end else if (ctl.emit_step) begin
			rsp_status_q <= ST_COMMIT_ENTRY;
			rsp_slot_q   <= 6'(emit_slot);
			rsp_blk_q    <= 32'(ram_rdata);
			rsp_last_q   <= emit_last;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.slot_index   = rsp_slot_q;
	assign rsp.logged_block = rsp_blk_q;
	assign rsp.last         = rsp_last_q;

	// The table never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(LOG_SLOTS))
		else $error("entry count beyond table depth");

	// A new slot is only taken while one is free.
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append |-> entry_cnt_q < CNT_W'(LOG_SLOTS))
		else $error("slot appended to a full table");

	// A result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_load || ctl.emit_step) |-> can_load)
		else $error("result register overwritten");

	// Commit emission walks only over logged slots.
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_step |-> (idx_q != '0 && idx_q <= entry_cnt_q))
		else $error("commit emission outside logged slots");

endmodule

`default_nettype wire

[rtl/journal_block_tracker.sv]
// Top level of the journal block tracker.
//
// Requests arrive on req (command, block_number) and results leave on rsp
// (status, slot_index, logged_block, last) with valid/ready handshakes.
// cfg_we with cfg_wdata sets the log area size in blocks; it is to be written
// by the user only while the block is idle, which the block does not enforce.
// Every request gives one result except an end that closes the last open
// operation with a non-empty table, which gives one commit entry per logged
// slot, in slot order, with last on the final one. Begin, end, commit done
// and rejected writes pass the execute and finish states before their result
// is registered. An accepted write walks the slot table through its single
// read port, one slot a cycle. Commit emission sends one entry per cycle
// while the receiver takes them. One request is worked on at a time;
// req.ready is high only while the controller waits for a request.
// A result sits in an output register, so a stalled receiver only holds the
// block when the next result is due. Reset empties the table, closes all
// operations, clears the commit flag and sets the log area size to 33.
`default_nettype none

module journal_block_tracker #(
	parameter int LOG_SLOTS  = 32,
	parameter int OP_RESERVE = 8,
	parameter int BLOCK_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	jbt_req_if.sink         req,
	jbt_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);
	import jbt_pkg::*;

	jbt_ctl_t  ctl;
	jbt_stat_t stat;

	// Sequencer.
	jbt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctl   (ctl)
	);

	// Counters, slot table and result register.
	jbt_datapath #(
		.LOG_SLOTS (LOG_SLOTS),
		.OP_RESERVE(OP_RESERVE),
		.BLOCK_BITS(BLOCK_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.ctl      (ctl),
		.stat     (stat)
	);

endmodule

`default_nettype wire

[test/journal_block_tracker_tb.sv]
// Self-checking testbench for the journal block tracker: random and directed requests.
`timescale 1ns / 1ps

module journal_block_tracker_tb;
	import jbt_pkg::*;

	localparam int unsigned LOG_SLOTS    = 32;
	localparam int unsigned OP_RESERVE   = 8;
	localparam int unsigned MAX_GAP      = 18;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// One expected result of the tracker.
	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
		logic [31:0] blk;
		logic        last;
	} journal_result_t;

	// Journal bookkeeping mirror and the queue of results it predicts.
	class journal_scoreboard;
		logic [31:0]     slots [LOG_SLOTS];
		int unsigned     logged_count;
		int unsigned     open_ops;
		bit              busy;
		int unsigned     log_area;
		journal_result_t pending [$];
		int unsigned     errors;

		function new();
			logged_count = 0;
			open_ops     = 0;
			busy         = 1'b0;
			log_area     = 33;
			errors       = 0;
		endfunction

		function void set_log_area(int unsigned blocks);
			log_area = blocks;
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction

		function void push(status_t status, int unsigned slot, logic [31:0] blk, logic last);
			journal_result_t want;
			want.status = status;
			want.slot   = 6'(slot);
			want.blk    = blk;
			want.last   = last;
			pending.push_back(want);
		endfunction

		// Work out the results of one accepted request and update the mirror.
		function void note_request(cmd_t cmd, logic [31:0] blk);
			int unsigned idx;
			case (cmd)
				CMD_BEGIN: begin
					if (busy)
						push(ST_WAIT_BUSY, 0, 0, 1'b1);
					else if (open_ops >= 63 ||
							logged_count + (open_ops + 1) * OP_RESERVE > LOG_SLOTS)
						push(ST_WAIT_ROOM, 0, 0, 1'b1);
					else begin
						open_ops++;
						push(ST_BEGUN, 0, 0, 1'b1);
					end
				end
				CMD_WRITE: begin
					if (logged_count >= LOG_SLOTS || logged_count + 1 >= log_area)
						push(ST_FULL, 0, 0, 1'b1);
					else if (open_ops == 0)
						push(ST_NO_OP, 0, 0, 1'b1);
					else begin
						// Reuse the slot that already holds this block.
						idx = 0;
						while (idx < logged_count && slots[idx] != blk)
							idx++;
						if (idx < logged_count)
							push(ST_ABSORBED, idx, blk, 1'b1);
						else begin
							slots[idx] = blk;
							logged_count++;
							push(ST_NEW_SLOT, idx, blk, 1'b1);
						end
					end
				end
				CMD_END: begin
					if (open_ops == 0)
						push(ST_NO_OP, 0, 0, 1'b1);
					else begin
						open_ops--;
						if (open_ops != 0)
							push(ST_ENDED, 0, 0, 1'b1);
						else begin
							// The last operation closed: the commit starts.
							busy = 1'b1;
							if (logged_count == 0)
								push(ST_ENDED, 0, 0, 1'b1);
							else
								for (int unsigned k = 0; k < logged_count; k++)
									push(ST_COMMIT_ENTRY, k, slots[k], k + 1 == logged_count);
						end
					end
				end
				default: begin
					logged_count = 0;
					busy         = 1'b0;
					push(ST_CLEARED, 0, 0, 1'b1);
				end
			endcase
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(logic [3:0] status, logic [5:0] slot, logic [31:0] blk,
				logic last);
			journal_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d slot %0d block %h", status, slot, blk);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (slot !== want.slot) begin
				$error("slot_index: expected %0d, got %0d", want.slot, slot);
				errors++;
			end
			if (blk !== want.blk) begin
				$error("logged_block: expected %h, got %h", want.blk, blk);
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	bit          no_idle;
	int unsigned sent_count;
	int unsigned cycle_count;
	logic [31:0] block_pool [6];

	journal_scoreboard sb = new();

	jbt_req_if req_bus ();
	jbt_rsp_if rsp_bus ();

	journal_block_tracker #(
		.LOG_SLOTS (LOG_SLOTS),
		.OP_RESERVE(OP_RESERVE),
		.BLOCK_BITS(32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_bus),
		.rsp      (rsp_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Check every result taken by the receiver.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
			sb.check_result(rsp_bus.status, rsp_bus.slot_index, rsp_bus.logged_block,
				rsp_bus.last);
	end

	// Receiver with a random stall before each result.
	initial begin : result_sink
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
		end
	end

	// Offer one request after a random gap and return at the falling edge after it is taken.
	task automatic send_request(cmd_t cmd, logic [31:0] blk);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.command      <= cmd;
		req_bus.block_number <= blk;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		sb.note_request(cmd, blk);
		sent_count++;
		@(negedge clk);
	endtask

	// Stop offering requests and let every expected result come out.
	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_log_area(logic [6:0] blocks);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= blocks;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_log_area(32'(blocks));
	endtask

	// Blocks from a small pool half of the time so that absorption happens, with some extremes.
	function automatic logic [31:0] pick_block();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return block_pool[$urandom_range(0, 5)];
		else if (roll < 9)
			return $urandom;
		else
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
	endfunction

	// Random phase: mostly whole operations, some stray commands.
	task automatic run_phase(logic [6:0] blocks, int unsigned target, bit fill);
		int unsigned start;
		int unsigned ops;
		int unsigned writes;
		write_log_area(blocks);
		foreach (block_pool[i])
			block_pool[i] = $urandom;
		start = sent_count;
		while (sent_count - start < target) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < 75) begin
				ops    = $urandom_range(1, 3);
				writes = fill ? $urandom_range(20, 36) : $urandom_range(0, 10);
				repeat (ops) send_request(CMD_BEGIN, $urandom);
				repeat (writes) send_request(CMD_WRITE, pick_block());
				repeat (ops) send_request(CMD_END, $urandom);
				if ($urandom_range(0, 9) < 7)
					send_request(CMD_COMMIT_DONE, $urandom);
			end else
				send_request(cmd_t'($urandom_range(0, 3)), pick_block());
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = 7'd0;
		no_idle              = 1'b0;
		sent_count           = 0;
		cycle_count          = 0;
		req_bus.valid        = 1'b0;
		req_bus.command      = CMD_BEGIN;
		req_bus.block_number = 32'd0;
		rsp_bus.ready        = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset log area size.
		send_request(CMD_END, 32'd0);
		send_request(CMD_WRITE, 32'hFFFF_FFFF);
		send_request(CMD_COMMIT_DONE, 32'd0);
		repeat (4) send_request(CMD_BEGIN, 32'd0);
		send_request(CMD_BEGIN, 32'd0);
		send_request(CMD_WRITE, 32'h0000_0000);
		send_request(CMD_WRITE, 32'hFFFF_FFFF);
		send_request(CMD_WRITE, 32'hFFFF_FFFF);
		send_request(CMD_WRITE, 32'hA5A5_A5A5);
		repeat (4) send_request(CMD_END, 32'd0);
		send_request(CMD_BEGIN, 32'd0);
		send_request(CMD_WRITE, 32'h5A5A_5A5A);
		send_request(CMD_COMMIT_DONE, 32'd0);
		send_request(CMD_BEGIN, 32'd0);
		send_request(CMD_COMMIT_DONE, 32'd0);
		send_request(CMD_END, 32'd0);
		send_request(CMD_END, 32'd0);
		send_request(CMD_COMMIT_DONE, 32'd0);

		// Random phases over several log area sizes, extremes included.
		run_phase(7'd33, 20, 1'b0);
		run_phase(7'd65, 25, 1'b1);
		run_phase(7'd2, 15, 1'b0);
		run_phase(7'd10, 15, 1'b0);
		run_phase(7'($urandom_range(3, 64)), 20, 1'b0);
		run_phase(7'd65, 15, 1'b0);

		wait_drained();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/jbt_pkg.sv
rtl/jbt_req_if.sv
rtl/jbt_rsp_if.sv
rtl/jbt_ram.sv
rtl/jbt_ctrl.sv
rtl/jbt_datapath.sv
rtl/journal_block_tracker.sv
test/journal_block_tracker_tb.sv
